@@ design/kvsp_pkg.sv @@
// shared types, codes and constants for the snapshot stream parser
`timescale 1ns / 1ps

package kvsp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_MARK   = 4'd1,
    PH_DBIDX  = 4'd2,
    PH_SIZEM  = 4'd3,
    PH_KCNT   = 4'd4,
    PH_ECNT   = 4'd5,
    PH_ENTRY  = 4'd6,
    PH_EXPB   = 4'd7,
    PH_VTYPE  = 4'd8,
    PH_SLEN   = 4'd9,
    PH_SLEN14 = 4'd10,
    PH_SLEN32 = 4'd11,
    PH_SBODY  = 4'd12,
    PH_SINT   = 4'd13,
    PH_DONE   = 4'd14,
    PH_ERR    = 4'd15
  } phase_e;

  // token kinds on the result channel
  typedef enum logic [2:0] {
    TK_HEADER_OK  = 3'd0,
    TK_STR_BYTE   = 3'd1,
    TK_STR_EMPTY  = 3'd2,
    TK_STR_INT    = 3'd3,
    TK_DB_SEL     = 3'd4,
    TK_KEY_COUNT  = 3'd5,
    TK_EXPIRY     = 3'd6,
    TK_ERROR      = 3'd7
  } tok_kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_MAGIC  = 3'd1,
    ERR_BAD_MARKER = 3'd2,
    ERR_BAD_SIZE   = 3'd3,
    ERR_BAD_ENC    = 3'd4
  } err_e;

  // string roles
  localparam logic [1:0] SEC_META_KEY = 2'd0;
  localparam logic [1:0] SEC_META_VAL = 2'd1;
  localparam logic [1:0] SEC_KEY      = 2'd2;
  localparam logic [1:0] SEC_VALUE    = 2'd3;

  // marker bytes
  localparam logic [7:0] OP_SELECTDB   = 8'hFE;
  localparam logic [7:0] OP_AUX        = 8'hFA;
  localparam logic [7:0] OP_RESIZEDB   = 8'hFB;
  localparam logic [7:0] OP_EXPIRE_MS  = 8'hFC;
  localparam logic [7:0] OP_EXPIRE_SEC = 8'hFD;
  localparam logic [5:0] LEN_LOW_MASK  = 6'h3F;

  // length encoding classes (top two bits of a length byte)
  localparam logic [1:0] ENC_LEN6    = 2'd0;
  localparam logic [1:0] ENC_LEN14   = 2'd1;
  localparam logic [1:0] ENC_LEN32   = 2'd2;

  // integer string widths
  localparam logic [1:0] INT_W8  = 2'd0;
  localparam logic [1:0] INT_W16 = 2'd1;

  localparam int unsigned MAGIC_LEN  = 5;
  localparam int unsigned HEADER_LEN = 9;
  localparam int unsigned MS_PER_SEC = 1000;

  // one result beat
  typedef struct packed {
    tok_kind_e          kind;
    logic [1:0]         section;
    logic [7:0]         byte_value;
    logic signed [31:0] int_value;
    logic               string_end;
    logic               expired;
    logic               expiry_in_ms;
    err_e               err_code;
    logic               records_done;
  } tok_t;

  // header magic, ascii
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    case (idx)
      3'd0:    m = 8'h52;
      3'd1:    m = 8'h45;
      3'd2:    m = 8'h44;
      3'd3:    m = 8'h49;
      3'd4:    m = 8'h53;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

@@ design/kvsp_parse.sv @@
// parser state and per-byte next-state and token logic
`timescale 1ns / 1ps

module kvsp_parse
  import kvsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic [63:0] now_ms_i,
  output logic        tok_valid_o,
  output tok_t        tok_o
);

  typedef struct packed {
    phase_e     phase;
    logic [1:0] role;
    logic [7:0] keys;
    logic       done;
  } fin_t;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [63:0] word_q, word_d;
  logic [1:0]  role_q, role_d;
  logic [1:0]  iwc_q, iwc_d;
  logic [7:0]  keys_q, keys_d;
  logic        unit_q, unit_d;
  err_e        err_q, err_d;

  logic [63:0] lane_word;
  logic [41:0] sec_prod;
  logic        exp_hit;
  logic [31:0] cnt_inc;
  logic [31:0] need;
  logic [31:0] int_v;
  logic        start;
  logic [31:0] start_len;
  fin_t        fin;

  // advance past a completed string
  function automatic fin_t finish(input logic [1:0] role, input logic [7:0] keys);
    fin_t f;
    f.phase = PH_SLEN;
    f.role  = role;
    f.keys  = keys;
    f.done  = 1'b0;
    case (role)
      SEC_META_KEY: begin
        f.role  = SEC_META_VAL;
        f.phase = PH_SLEN;
      end
      SEC_META_VAL: f.phase = PH_MARK;
      SEC_KEY: begin
        f.role  = SEC_VALUE;
        f.phase = PH_SLEN;
      end
      default: begin
        f.keys = keys - 8'd1;
        if (f.keys == 8'd0) begin
          f.phase = PH_DONE;
          f.done  = 1'b1;
        end else begin
          f.phase = PH_ENTRY;
        end
      end
    endcase
    return f;
  endfunction

  // byte lane merge and expiry compare
  always_comb begin
    lane_word = word_q | ({56'd0, data_byte_i} << {cnt_q[2:0], 3'b000});
    sec_prod  = {10'd0, lane_word[31:0]} * 42'(MS_PER_SEC);
    if (unit_q) begin
      exp_hit = (lane_word <= now_ms_i);
    end else begin
      exp_hit = ({22'd0, sec_prod} <= now_ms_i);
    end
    cnt_inc = cnt_q + 32'd1;
    fin     = finish(role_q, keys_q);
  end

  // integer string width and sign extension
  always_comb begin
    if (iwc_q == INT_W8) begin
      need  = 32'd1;
      int_v = {{24{lane_word[7]}}, lane_word[7:0]};
    end else if (iwc_q == INT_W16) begin
      need  = 32'd2;
      int_v = {{16{lane_word[15]}}, lane_word[15:0]};
    end else begin
      need  = 32'd4;
      int_v = lane_word[31:0];
    end
  end

  // next state and token
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    role_d      = role_q;
    iwc_d       = iwc_q;
    keys_d      = keys_q;
    unit_d      = unit_q;
    err_d       = err_q;
    tok_valid_o = 1'b0;
    tok_o       = '0;
    start       = 1'b0;
    start_len   = 32'd0;

    case (phase_q)
      PH_HDR: begin
        if (cnt_q < 32'(MAGIC_LEN) && data_byte_i != magic_byte(cnt_q[2:0])) begin
          phase_d      = PH_ERR;
          err_d        = ERR_BAD_MAGIC;
          tok_valid_o  = 1'b1;
          tok_o.kind   = TK_ERROR;
          tok_o.err_code = ERR_BAD_MAGIC;
        end else if (cnt_inc >= 32'(HEADER_LEN)) begin
          cnt_d       = 32'd0;
          phase_d     = PH_MARK;
          tok_valid_o = 1'b1;
          tok_o.kind  = TK_HEADER_OK;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_MARK: begin
        if (data_byte_i == OP_SELECTDB) begin
          phase_d = PH_DBIDX;
        end else if (data_byte_i == OP_AUX) begin
          role_d  = SEC_META_KEY;
          phase_d = PH_SLEN;
        end else begin
          phase_d        = PH_ERR;
          err_d          = ERR_BAD_MARKER;
          tok_valid_o    = 1'b1;
          tok_o.kind     = TK_ERROR;
          tok_o.err_code = ERR_BAD_MARKER;
        end
      end
      PH_DBIDX: begin
        phase_d          = PH_SIZEM;
        tok_valid_o      = 1'b1;
        tok_o.kind       = TK_DB_SEL;
        tok_o.byte_value = data_byte_i;
      end
      PH_SIZEM: begin
        if (data_byte_i != OP_RESIZEDB) begin
          phase_d        = PH_ERR;
          err_d          = ERR_BAD_SIZE;
          tok_valid_o    = 1'b1;
          tok_o.kind     = TK_ERROR;
          tok_o.err_code = ERR_BAD_SIZE;
        end else begin
          phase_d = PH_KCNT;
        end
      end
      PH_KCNT: begin
        keys_d           = data_byte_i;
        phase_d          = PH_ECNT;
        tok_valid_o      = 1'b1;
        tok_o.kind       = TK_KEY_COUNT;
        tok_o.byte_value = data_byte_i;
      end
      PH_ECNT: begin
        phase_d = (keys_q == 8'd0) ? PH_DONE : PH_ENTRY;
      end
      PH_ENTRY: begin
        if (data_byte_i == OP_EXPIRE_MS || data_byte_i == OP_EXPIRE_SEC) begin
          unit_d  = (data_byte_i == OP_EXPIRE_MS);
          cnt_d   = 32'd0;
          word_d  = 64'd0;
          phase_d = PH_EXPB;
        end else begin
          role_d  = SEC_KEY;
          phase_d = PH_SLEN;
        end
      end
      PH_EXPB: begin
        word_d = lane_word;
        if (cnt_inc < (unit_q ? 32'd8 : 32'd4)) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d              = 32'd0;
          phase_d            = PH_VTYPE;
          tok_valid_o        = 1'b1;
          tok_o.kind         = TK_EXPIRY;
          tok_o.expired      = exp_hit;
          tok_o.expiry_in_ms = unit_q;
        end
      end
      PH_VTYPE: begin
        role_d  = SEC_KEY;
        phase_d = PH_SLEN;
      end
      PH_SLEN: begin
        case (data_byte_i[7:6])
          ENC_LEN6: begin
            start     = 1'b1;
            start_len = {26'd0, data_byte_i[5:0] & LEN_LOW_MASK};
          end
          ENC_LEN14: begin
            word_d  = {58'd0, data_byte_i[5:0]};
            phase_d = PH_SLEN14;
          end
          ENC_LEN32: begin
            word_d  = 64'd0;
            cnt_d   = 32'd0;
            phase_d = PH_SLEN32;
          end
          default: begin
            if (data_byte_i[5:0] > 6'd2) begin
              phase_d        = PH_ERR;
              err_d          = ERR_BAD_ENC;
              tok_valid_o    = 1'b1;
              tok_o.kind     = TK_ERROR;
              tok_o.err_code = ERR_BAD_ENC;
            end else begin
              iwc_d   = data_byte_i[1:0];
              word_d  = 64'd0;
              cnt_d   = 32'd0;
              phase_d = PH_SINT;
            end
          end
        endcase
      end
      PH_SLEN14: begin
        start     = 1'b1;
        start_len = {18'd0, word_q[5:0], data_byte_i};
      end
      PH_SLEN32: begin
        word_d = lane_word;
        cnt_d  = cnt_inc;
        if (cnt_inc >= 32'd4) begin
          start     = 1'b1;
          start_len = lane_word[31:0];
        end
      end
      PH_SBODY: begin
        cnt_d            = cnt_q - 32'd1;
        tok_valid_o      = 1'b1;
        tok_o.kind       = TK_STR_BYTE;
        tok_o.section    = role_q;
        tok_o.byte_value = data_byte_i;
        if (cnt_q == 32'd1) begin
          tok_o.string_end   = 1'b1;
          tok_o.records_done = fin.done;
          phase_d            = fin.phase;
          role_d             = fin.role;
          keys_d             = fin.keys;
        end
      end
      PH_SINT: begin
        word_d = lane_word;
        if (cnt_inc < need) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d              = 32'd0;
          tok_valid_o        = 1'b1;
          tok_o.kind         = TK_STR_INT;
          tok_o.section      = role_q;
          tok_o.int_value    = int_v;
          tok_o.records_done = fin.done;
          phase_d            = fin.phase;
          role_d             = fin.role;
          keys_d             = fin.keys;
        end
      end
      PH_ERR: begin
        tok_valid_o    = 1'b1;
        tok_o.kind     = TK_ERROR;
        tok_o.err_code = err_q;
      end
      default: ;
    endcase

    // string body start, empty string gives a token at once
    if (start) begin
      if (start_len == 32'd0) begin
        tok_valid_o        = 1'b1;
        tok_o.kind         = TK_STR_EMPTY;
        tok_o.section      = role_q;
        tok_o.records_done = fin.done;
        phase_d            = fin.phase;
        role_d             = fin.role;
        keys_d             = fin.keys;
      end else begin
        cnt_d   = start_len;
        phase_d = PH_SBODY;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      cnt_q   <= 32'd0;
      word_q  <= 64'd0;
      role_q  <= 2'd0;
      iwc_q   <= 2'd0;
      keys_q  <= 8'd0;
      unit_q  <= 1'b0;
      err_q   <= ERR_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      word_q  <= word_d;
      role_q  <= role_d;
      iwc_q   <= iwc_d;
      keys_q  <= keys_d;
      unit_q  <= unit_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ design/keyvalue_snapshot_parser_unit.sv @@
// Snapshot stream parser: one byte per beat in, at most one token per byte out.
// Stages: input register, result register. Each byte: phase update plus expiry compare.
// Throughput: one byte per cycle while the result register is not stalled.
// Reset (rst_ni low, asynchronous): parser returns to the header phase, both stages empty.
`timescale 1ns / 1ps

module keyvalue_snapshot_parser_unit
  import kvsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic [63:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         token_kind_o,
  output logic [1:0]         section_o,
  output logic [7:0]         byte_value_o,
  output logic signed [31:0] int_value_o,
  output logic               string_end_o,
  output logic               expired_o,
  output logic               expiry_in_ms_o,
  output logic [2:0]         error_code_o,
  output logic               records_done_o
);

  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic [63:0] now_q;
  logic        out_vld_q;
  tok_t        out_q;

  logic        step;
  logic        load;
  logic        tok_valid;
  tok_t        tok;

  // stage handshake
  assign step       = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign load       = in_valid_i && !in_stall_o;

  kvsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .now_ms_i    (now_q),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
      now_q  <= now_ms_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= tok_valid;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && tok_valid) begin
      out_q <= tok;
    end
  end

  // result beat fields
  assign out_valid_o    = out_vld_q;
  assign token_kind_o   = out_q.kind;
  assign section_o      = out_q.section;
  assign byte_value_o   = out_q.byte_value;
  assign int_value_o    = out_q.int_value;
  assign string_end_o   = out_q.string_end;
  assign expired_o      = out_q.expired;
  assign expiry_in_ms_o = out_q.expiry_in_ms;
  assign error_code_o   = out_q.err_code;
  assign records_done_o = out_q.records_done;

endmodule

@@ tb/keyvalue_snapshot_parser_unit_test.sv @@
// self-checking testbench for the snapshot stream parser: byte stream in, token stream checked
`timescale 1ns / 1ps

module keyvalue_snapshot_parser_unit_test;
  import kvsp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_KEYS    = 144;
  localparam int unsigned TRAIL_BYTES = 16;
  localparam int unsigned PRINT_CAP   = 200;
  localparam logic [1:0]  ENC_INT     = 2'd3;
  localparam logic [1:0]  INT_W32     = 2'd2;
  // ascii signature at the head of every snapshot file
  localparam logic [7:0]  SIGNATURE [MAGIC_LEN] = '{8'h52, 8'h45, 8'h44, 8'h49, 8'h53};

  typedef enum int {VAL_NORMAL, VAL_BROKEN, VAL_LONG} value_mode_e;
  typedef enum int {END_COMPLETE, END_BAD_ENCODING} ending_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i = 8'd0;
  logic [63:0]        now_ms_i    = 64'd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         token_kind_o;
  logic [1:0]         section_o;
  logic [7:0]         byte_value_o;
  logic signed [31:0] int_value_o;
  logic               string_end_o;
  logic               expired_o;
  logic               expiry_in_ms_o;
  logic [2:0]         error_code_o;
  logic               records_done_o;

  // tokens the parser owes us, oldest first
  tok_t        expected_tokens[$];
  int unsigned mismatches     = 0;
  int unsigned tokens_checked = 0;
  int unsigned bytes_sent     = 0;
  int unsigned entries_sent   = 0;
  int unsigned expiries_sent  = 0;
  int unsigned quiet_cycles   = 0;
  bit          steady         = 1'b0;
  ending_e     ending         = END_COMPLETE;

  // parser state as the predictor sees it
  phase_e      parse_ph    = PH_HDR;
  logic [31:0] step_count  = '0;
  logic [63:0] gathered    = '0;
  logic [1:0]  str_role    = SEC_META_KEY;
  logic [1:0]  int_w       = INT_W8;
  logic [7:0]  keys_left   = '0;
  logic        unit_is_ms  = 1'b0;

  keyvalue_snapshot_parser_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .section_o      (section_o),
    .byte_value_o   (byte_value_o),
    .int_value_o    (int_value_o),
    .string_end_o   (string_end_o),
    .expired_o      (expired_o),
    .expiry_in_ms_o (expiry_in_ms_o),
    .error_code_o   (error_code_o),
    .records_done_o (records_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------- predictor

  // move on after a finished string; done marks the end of the last entry
  task automatic close_string(output logic done);
    done = 1'b0;
    case (str_role)
      SEC_META_KEY: begin
        str_role = SEC_META_VAL;
        parse_ph = PH_SLEN;
      end
      SEC_META_VAL: parse_ph = PH_MARK;
      SEC_KEY: begin
        str_role = SEC_VALUE;
        parse_ph = PH_SLEN;
      end
      default: begin
        keys_left = keys_left - 8'd1;
        if (keys_left == 8'd0) begin
          parse_ph = PH_DONE;
          done     = 1'b1;
        end else begin
          parse_ph = PH_ENTRY;
        end
      end
    endcase
  endtask

  task automatic raise_error(input err_e code, output bit emit, output tok_t tok);
    parse_ph     = PH_ERR;
    gathered     = 64'(code);
    tok          = '0;
    tok.kind     = TK_ERROR;
    tok.err_code = code;
    emit         = 1'b1;
  endtask

  // a zero length is an empty-string token, anything else opens a body
  task automatic open_body(input logic [31:0] len, output bit emit, output tok_t tok);
    logic done;
    tok  = '0;
    emit = 1'b0;
    if (len == 32'd0) begin
      tok.kind    = TK_STR_EMPTY;
      tok.section = str_role;
      close_string(done);
      tok.records_done = done;
      emit = 1'b1;
    end else begin
      step_count = len;
      parse_ph   = PH_SBODY;
    end
  endtask

  // one accepted byte in, at most one token out
  task automatic parse_byte(input logic [7:0] b, input logic [63:0] now,
                            output bit emit, output tok_t tok);
    logic [31:0] need;
    logic [31:0] v;
    logic [1:0]  sec;
    logic        done;
    emit = 1'b0;
    tok  = '0;
    need = '0;
    v    = '0;
    sec  = '0;
    done = 1'b0;
    case (parse_ph)
      PH_HDR: begin
        if (step_count < MAGIC_LEN && b != SIGNATURE[step_count]) begin
          raise_error(ERR_BAD_MAGIC, emit, tok);
        end else begin
          step_count++;
          if (step_count >= HEADER_LEN) begin
            step_count = '0;
            parse_ph   = PH_MARK;
            tok.kind   = TK_HEADER_OK;
            emit       = 1'b1;
          end
        end
      end
      PH_MARK: begin
        if (b == OP_SELECTDB) begin
          parse_ph = PH_DBIDX;
        end else if (b == OP_AUX) begin
          str_role = SEC_META_KEY;
          parse_ph = PH_SLEN;
        end else begin
          raise_error(ERR_BAD_MARKER, emit, tok);
        end
      end
      PH_DBIDX: begin
        parse_ph       = PH_SIZEM;
        tok.kind       = TK_DB_SEL;
        tok.byte_value = b;
        emit           = 1'b1;
      end
      PH_SIZEM: begin
        if (b != OP_RESIZEDB) raise_error(ERR_BAD_SIZE, emit, tok);
        else parse_ph = PH_KCNT;
      end
      PH_KCNT: begin
        keys_left      = b;
        parse_ph       = PH_ECNT;
        tok.kind       = TK_KEY_COUNT;
        tok.byte_value = b;
        emit           = 1'b1;
      end
      PH_ECNT: parse_ph = (keys_left == 8'd0) ? PH_DONE : PH_ENTRY;
      PH_ENTRY: begin
        if (b == OP_EXPIRE_MS || b == OP_EXPIRE_SEC) begin
          unit_is_ms = (b == OP_EXPIRE_MS);
          step_count = '0;
          gathered   = '0;
          parse_ph   = PH_EXPB;
        end else begin
          str_role = SEC_KEY;
          parse_ph = PH_SLEN;
        end
      end
      PH_EXPB: begin
        need     = unit_is_ms ? 32'd8 : 32'd4;
        gathered = gathered | (64'(b) << (8 * step_count[2:0]));
        step_count++;
        if (step_count >= need) begin
          step_count = '0;
          tok.kind   = TK_EXPIRY;
          tok.expired = unit_is_ms ? (gathered <= now)
                                   : ((64'(gathered[31:0]) * 64'(MS_PER_SEC)) <= now);
          tok.expiry_in_ms = unit_is_ms;
          parse_ph = PH_VTYPE;
          emit     = 1'b1;
        end
      end
      PH_VTYPE: begin
        str_role = SEC_KEY;
        parse_ph = PH_SLEN;
      end
      PH_SLEN: begin
        case (b[7:6])
          ENC_LEN6: open_body({26'd0, b[5:0]}, emit, tok);
          ENC_LEN14: begin
            gathered = {58'd0, b[5:0]};
            parse_ph = PH_SLEN14;
          end
          ENC_LEN32: begin
            gathered   = '0;
            step_count = '0;
            parse_ph   = PH_SLEN32;
          end
          default: begin
            if (b[5:0] > 6'd2) begin
              raise_error(ERR_BAD_ENC, emit, tok);
            end else begin
              int_w      = b[1:0];
              gathered   = '0;
              step_count = '0;
              parse_ph   = PH_SINT;
            end
          end
        endcase
      end
      PH_SLEN14: open_body({18'd0, gathered[5:0], b}, emit, tok);
      PH_SLEN32: begin
        gathered = gathered | (64'(b) << (8 * step_count[1:0]));
        step_count++;
        if (step_count >= 32'd4) open_body(gathered[31:0], emit, tok);
      end
      PH_SBODY: begin
        sec = str_role;
        step_count--;
        if (step_count == 32'd0) begin
          tok.string_end = 1'b1;
          close_string(done);
          tok.records_done = done;
        end
        tok.kind       = TK_STR_BYTE;
        tok.section    = sec;
        tok.byte_value = b;
        emit           = 1'b1;
      end
      PH_SINT: begin
        need     = (int_w == INT_W8) ? 32'd1 : (int_w == INT_W16) ? 32'd2 : 32'd4;
        gathered = gathered | (64'(b) << (8 * step_count[1:0]));
        step_count++;
        if (step_count >= need) begin
          step_count = '0;
          v = gathered[31:0];
          if (need == 32'd1 && v[7])  v[31:8]  = '1;
          if (need == 32'd2 && v[15]) v[31:16] = '1;
          sec = str_role;
          close_string(done);
          tok.kind         = TK_STR_INT;
          tok.section      = sec;
          tok.int_value    = v;
          tok.records_done = done;
          emit = 1'b1;
        end
      end
      PH_ERR: begin
        tok.kind     = TK_ERROR;
        tok.err_code = err_e'(gathered[2:0]);
        emit         = 1'b1;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("token %0d %s got %0h want %0h",
                                tokens_checked, name, got, want));
  endtask

  // compare every accepted token beat with the oldest prediction
  always @(posedge clk_i) begin : check_tokens
    tok_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token of kind %0d", token_kind_o));
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", token_kind_o, want.kind);
        check_field("section", section_o, want.section);
        check_field("byte_value", byte_value_o, want.byte_value);
        check_field("int_value", int_value_o, want.int_value);
        check_field("string_end", string_end_o, want.string_end);
        check_field("expired", expired_o, want.expired);
        check_field("expiry_in_ms", expiry_in_ms_o, want.expiry_in_ms);
        check_field("error_code", error_code_o, want.err_code);
        check_field("records_done", records_done_o, want.records_done);
        tokens_checked++;
      end
    end
  end

  // receiver stalls at random outside the steady stretch
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 11);
  end

  // give up when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one byte beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic [63:0] now);
    bit   emit;
    tok_t tok;
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    now_ms_i    <= now;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    parse_byte(b, now, emit, tok);
    if (emit) expected_tokens.push_back(tok);
  endtask

  // hold the sender until every owed token has come out
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_length(input logic [1:0] enc, input logic [31:0] len);
    case (enc)
      ENC_LEN6: send_byte({ENC_LEN6, len[5:0]}, rnd64());
      ENC_LEN14: begin
        send_byte({ENC_LEN14, len[13:8]}, rnd64());
        send_byte(len[7:0], rnd64());
      end
      default: begin
        // low six bits of a 32-bit length marker are don't-care
        send_byte({ENC_LEN32, 6'($urandom)}, rnd64());
        for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8], rnd64());
      end
    endcase
  endtask

  task automatic send_raw_string(input logic [1:0] enc, input int unsigned len);
    send_length(enc, len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom), rnd64());
  endtask

  task automatic send_int_string(input logic [1:0] w, input logic [31:0] v);
    int n;
    n = (w == INT_W8) ? 1 : (w == INT_W16) ? 2 : 4;
    send_byte({ENC_INT, 4'd0, w}, rnd64());
    for (int i = 0; i < n; i++) send_byte(v[8 * i +: 8], rnd64());
  endtask

  // mostly short strings across all length encodings, plus integer strings
  task automatic send_any_string();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      send_raw_string(ENC_LEN6, $urandom_range(0, 4));
    else if (r < 60) send_raw_string(ENC_LEN14, $urandom_range(0, 4));
    else if (r < 70) send_raw_string(ENC_LEN32, $urandom_range(0, 3));
    else             send_int_string(2'($urandom_range(0, 2)), $urandom);
  endtask

  // expiry marker and stamp; now only matters on the last stamp byte
  task automatic send_expiry(input bit ms, input logic [63:0] stamp, input logic [63:0] now);
    int n;
    n = ms ? 8 : 4;
    send_byte(ms ? OP_EXPIRE_MS : OP_EXPIRE_SEC, rnd64());
    for (int i = 0; i < n; i++) send_byte(stamp[8 * i +: 8], (i == n - 1) ? now : rnd64());
    expiries_sent++;
  endtask

  // stamps land on, just before or just after the current time, or against a random time
  task automatic send_random_expiry();
    bit          ms;
    logic [63:0] stamp;
    logic [63:0] limit;
    logic [63:0] now;
    ms    = $urandom_range(0, 1);
    stamp = ms ? rnd64() : {32'd0, $urandom};
    limit = ms ? stamp : 64'(stamp[31:0]) * 64'(MS_PER_SEC);
    case ($urandom_range(0, 3))
      0:       now = limit;
      1:       now = limit - 64'd1;
      2:       now = limit + 64'd1;
      default: now = rnd64();
    endcase
    send_expiry(ms, stamp, now);
  endtask

  task automatic send_key_value(input value_mode_e mode);
    send_any_string();
    case (mode)
      VAL_BROKEN: send_byte({ENC_INT, 6'($urandom_range(3, 63))}, rnd64());
      VAL_LONG:   send_raw_string(ENC_LEN14, 256 + $urandom_range(0, 63));
      default:    send_any_string();
    endcase
    entries_sent++;
  endtask

  task automatic send_entry(input value_mode_e mode);
    logic [7:0] vt;
    if ($urandom_range(0, 99) < 30) begin
      send_random_expiry();
      send_byte(8'($urandom), rnd64());
    end else begin
      // without an expiry the type byte must not look like an expiry marker
      do vt = 8'($urandom); while (vt == OP_EXPIRE_MS || vt == OP_EXPIRE_SEC);
      send_byte(vt, rnd64());
    end
    send_key_value(mode);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_header();
    for (int i = 0; i < MAGIC_LEN; i++) send_byte(SIGNATURE[i], rnd64());
    send_byte(8'h00, 64'd0);
    send_byte(8'hFF, '1);
    send_byte(8'($urandom), rnd64());
    send_byte(8'($urandom), rnd64());
  endtask

  // metadata pairs: empty string, integer extremes, 14- and 32-bit lengths
  task automatic test_metadata();
    send_byte(OP_AUX, rnd64());
    send_raw_string(ENC_LEN6, 0);
    send_int_string(INT_W8, 32'h0000_0080);
    send_byte(OP_AUX, rnd64());
    send_int_string(INT_W16, 32'h0000_7FFF);
    send_int_string(INT_W32, 32'h8000_0000);
    send_byte(OP_AUX, rnd64());
    send_raw_string(ENC_LEN14, 2);
    send_raw_string(ENC_LEN32, 1);
    send_byte(OP_AUX, rnd64());
    send_int_string(INT_W8, 32'h0000_007F);
    send_int_string(INT_W16, 32'h0000_8000);
    drain_tokens();
  endtask

  task automatic test_database();
    send_byte(OP_SELECTDB, rnd64());
    send_byte(8'($urandom), rnd64());
    send_byte(OP_RESIZEDB, rnd64());
    send_byte(8'(NUM_KEYS), rnd64());
    send_byte(8'($urandom), rnd64());
  endtask

  // expiry stamps at the ends of their ranges
  task automatic test_expiry_edges();
    send_expiry(1'b1, '1, '1);
    send_byte(8'($urandom), rnd64());
    send_key_value(VAL_NORMAL);
    send_expiry(1'b1, 64'd1, 64'd0);
    send_byte(8'($urandom), rnd64());
    send_key_value(VAL_NORMAL);
    send_expiry(1'b0, 64'hFFFF_FFFF, 64'hFFFF_FFFF * 64'(MS_PER_SEC) - 64'd1);
    send_byte(8'($urandom), rnd64());
    send_key_value(VAL_NORMAL);
    send_expiry(1'b0, 64'd0, 64'd0);
    send_byte(8'($urandom), rnd64());
    send_key_value(VAL_NORMAL);
  endtask

  // random entries up to the last one, with a stretch free of idles and stalls
  task automatic test_random_entries();
    while (entries_sent < NUM_KEYS - 1) begin
      steady = (entries_sent >= 100 && entries_sent < 160);
      send_entry(entries_sent == 40 ? VAL_LONG : VAL_NORMAL);
    end
    steady = 1'b0;
  endtask

  // last entry completes the file or breaks it, then bytes after the end
  task automatic test_ending();
    ending = $urandom_range(0, 1) ? END_COMPLETE : END_BAD_ENCODING;
    send_entry(ending == END_COMPLETE ? VAL_NORMAL : VAL_BROKEN);
    for (int i = 0; i < TRAIL_BYTES; i++) send_byte(8'($urandom), rnd64());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header();
    test_metadata();
    test_database();
    test_expiry_edges();
    test_random_entries();
    test_ending();
    drain_tokens();
    repeat (8) @(posedge clk_i);
    $display("stream of %0d bytes: header, 4 metadata pairs, %0d entries, %0d with expiry",
             bytes_sent, entries_sent, expiries_sent);
    $display("%0d tokens checked, stream closed by %s", tokens_checked, ending.name());
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
